### src/jadm_pkg.sv
// shared types and constants for the joystick axis dead-zone mapper
// used by jadm_lane and joystick_axis_deadzone_mapper_core; no dependencies
package jadm_pkg;

  localparam int AXIS_COUNT = 4;
  localparam int SAMPLE_W   = 12;
  localparam int AXIS_W     = 8;
  localparam int REG_IDX_W  = 2;

  localparam logic [SAMPLE_W-1:0] FAIL_VALUE = 12'd1024;
  localparam logic [SAMPLE_W-1:0] CLAMP_HIGH = 12'd1700;
  localparam logic [SAMPLE_W-1:0] CLAMP_LOW  = 12'd100;
  localparam logic [SAMPLE_W-1:0] DEAD_BAND  = 12'd100;
  localparam logic [AXIS_W-1:0]   AXIS_MID   = 8'd128;
  localparam logic [AXIS_W-1:0]   AXIS_FULL  = 8'd255;

  // quotient always stays below 128, so seven restoring steps suffice
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;
  localparam int NUM_W     = 18;

  localparam int AXIS_X  = 0;
  localparam int AXIS_Y  = 1;
  localparam int AXIS_RZ = 2;
  localparam int AXIS_Z  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_CENTER  = 2'd0,
    REG_Y_CENTER  = 2'd1,
    REG_RZ_CENTER = 2'd2,
    REG_Z_CENTER  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MERGE
  } state_t;

  typedef enum logic [1:0] {
    BR_MID,
    BR_UP,
    BR_LO
  } branch_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

### src/joystick_axis_deadzone_mapper_core.sv
// top level of the joystick axis dead-zone mapper: four lanes, merge and
// change detection, output register; depends on jadm_pkg and jadm_lane
//
// channel  | signals                                          | handshake
// ---------+--------------------------------------------------+-----------
// input    | x/y/rz/z_sample, read_fail_mask                  | in_valid/in_ready
// output   | x/y/rz/z_axis                                    | out_valid/out_ready
// config   | cfg_index, cfg_data                              | cfg_we, no wait
//
// a transaction runs from acceptance to the merge in this order: the lanes load at
// acceptance, seven divider steps follow, S_DIV sees them done, S_MERGE merges;
// no new poll is accepted before the state has returned from S_MERGE to S_IDLE
// a result waits in the output register while the next poll runs; only the
// merge of that poll, if its axes changed, stalls while the register is full
// synchronous reset clears the control, the centers to 0 and last axes to 128
module joystick_axis_deadzone_mapper_core (
  input  logic                           clk,
  input  logic                           rst,
  // input transaction
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [jadm_pkg::SAMPLE_W-1:0]  x_sample,
  input  logic [jadm_pkg::SAMPLE_W-1:0]  y_sample,
  input  logic [jadm_pkg::SAMPLE_W-1:0]  rz_sample,
  input  logic [jadm_pkg::SAMPLE_W-1:0]  z_sample,
  input  logic [jadm_pkg::AXIS_COUNT-1:0] read_fail_mask,
  // result transaction
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jadm_pkg::AXIS_W-1:0]    x_axis,
  output logic [jadm_pkg::AXIS_W-1:0]    y_axis,
  output logic [jadm_pkg::AXIS_W-1:0]    rz_axis,
  output logic [jadm_pkg::AXIS_W-1:0]    z_axis,
  // register writes
  input  logic                           cfg_we,
  input  logic [jadm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [jadm_pkg::SAMPLE_W-1:0]  cfg_data
);
  import jadm_pkg::*;

  state_t state, state_next;

  logic [SAMPLE_W-1:0] centers   [AXIS_COUNT];
  logic [SAMPLE_W-1:0] samples   [AXIS_COUNT];
  logic [AXIS_W-1:0]   lane_axis [AXIS_COUNT];
  logic [AXIS_W-1:0]   new_axes  [AXIS_COUNT];
  logic [AXIS_W-1:0]   last_axes [AXIS_COUNT];
  lane_stat_t          lane_stat [AXIS_COUNT];

  logic [AXIS_COUNT-1:0] lane_done;
  logic [AXIS_COUNT-1:0] lane_busy;
  logic [AXIS_COUNT-1:0] axis_diff;
  logic                  all_done;
  logic                  changed;
  logic                  slot_free;
  logic                  load;
  logic                  start;

  assign samples[AXIS_X]  = x_sample;
  assign samples[AXIS_Y]  = y_sample;
  assign samples[AXIS_RZ] = rz_sample;
  assign samples[AXIS_Z]  = z_sample;

  assign start = in_valid && in_ready;

  // register file for the calibrated centers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        centers[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_CENTER:  centers[AXIS_X]  <= cfg_data;
        REG_Y_CENTER:  centers[AXIS_Y]  <= cfg_data;
        REG_RZ_CENTER: centers[AXIS_RZ] <= cfg_data;
        REG_Z_CENTER:  centers[AXIS_Z]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one lane per axis, all started together and finishing together
  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
    jadm_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (start),
      .sample (samples[g]),
      .fail   (read_fail_mask[g]),
      .center (centers[g]),
      .axis   (lane_axis[g]),
      .stat   (lane_stat[g])
    );
    assign lane_done[g] = lane_stat[g].done;
    assign lane_busy[g] = lane_stat[g].busy;
  end

  // merge: y is inverted, then every axis is compared with the last report
  always_comb begin
    for (int i = 0; i < AXIS_COUNT; i++) begin
      new_axes[i]  = (i == AXIS_Y) ? (AXIS_FULL - lane_axis[i]) : lane_axis[i];
      axis_diff[i] = new_axes[i] != last_axes[i];
    end
  end

  assign all_done  = &lane_done;
  assign changed   = |axis_diff;
  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_DIV;
      S_DIV:   if (all_done) state_next = S_MERGE;
      S_MERGE: if (!changed || slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_DIV:   ;
      S_MERGE: load = changed && slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // last reported axes move with the output register load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        last_axes[i] <= AXIS_MID;
      end
    end else if (load) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        last_axes[i] <= new_axes[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_axis  <= new_axes[AXIS_X];
      y_axis  <= new_axes[AXIS_Y];
      rz_axis <= new_axes[AXIS_RZ];
      z_axis  <= new_axes[AXIS_Z];
    end
  end

  // a pending result always matches the remembered axes
  a_out_matches_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (x_axis == last_axes[AXIS_X]) && (y_axis == last_axes[AXIS_Y]) &&
                  (rz_axis == last_axes[AXIS_RZ]) && (z_axis == last_axes[AXIS_Z]))
    else $error("output register differs from last reported axes");

  // no poll is taken while any divider is still iterating
  a_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (lane_busy == '0))
    else $error("input accepted while a lane is busy");

  // lanes run in lockstep: the merge only sees finished quotients
  a_merge_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> all_done && (lane_busy == '0))
    else $error("merge with unfinished lanes");

  // an accepted poll starts every lane
  a_start_lanes: assert property (@(posedge clk) disable iff (rst)
    start |=> (lane_busy == {AXIS_COUNT{1'b1}}) && (state == S_DIV))
    else $error("lanes not started on accepted poll");

endmodule

### src/jadm_lane.sv
// one axis lane: fail substitution, clamp, dead-zone test and a 7-step
// restoring divider for the scaled offset; depends on jadm_pkg
module jadm_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [jadm_pkg::SAMPLE_W-1:0] sample,
  input  logic                          fail,
  input  logic [jadm_pkg::SAMPLE_W-1:0] center,
  output logic [jadm_pkg::AXIS_W-1:0]   axis,
  output jadm_pkg::lane_stat_t          stat
);
  import jadm_pkg::*;

  logic [SAMPLE_W-1:0] v_raw;
  logic [10:0]         v_clp;
  logic                upper;
  logic                lower;
  logic [10:0]         x_op;
  logic [NUM_W-1:0]    num;
  logic [SAMPLE_W-1:0] den_init;
  branch_t             br_init;

  logic [SAMPLE_W-1:0] rem;
  logic [DIV_STEPS-1:0] quo;
  logic [SAMPLE_W-1:0] den;
  branch_t             br;
  logic [STEP_W-1:0]   cnt;
  logic                busy;
  logic                done;

  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                ge;

  always_comb begin
    v_raw = fail ? FAIL_VALUE : sample;
    if (v_raw > CLAMP_HIGH) begin
      v_clp = CLAMP_HIGH[10:0];
    end else if (v_raw < CLAMP_LOW) begin
      v_clp = '0;
    end else begin
      v_clp = v_raw[10:0];
    end
    upper = {2'b00, v_clp} > ({1'b0, center} + {1'b0, DEAD_BAND});
    lower = ({2'b00, v_clp} + {1'b0, DEAD_BAND}) < {1'b0, center};
    // upper implies center below 1600, so the 11-bit difference is exact
    x_op  = upper ? (v_clp - center[10:0]) : v_clp;
    num   = {x_op, 7'b0} - {7'b0, x_op};
    den_init = upper ? (CLAMP_HIGH - center) : (center - DEAD_BAND);
    if (upper) begin
      br_init = BR_UP;
    end else if (lower) begin
      br_init = BR_LO;
    end else begin
      br_init = BR_MID;
    end
  end

  assign trial = {rem, quo[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num[NUM_W-1:DIV_STEPS]};
      quo <= num[DIV_STEPS-1:0];
      den <= den_init;
      br  <= br_init;
    end else if (busy) begin
      rem <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      quo <= {quo[DIV_STEPS-2:0], ge};
    end
  end

  always_comb begin
    case (br)
      BR_UP:   axis = {1'b1, quo};
      BR_LO:   axis = {1'b0, quo};
      default: axis = AXIS_MID;
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
